// File: hw/rtl/wsfd_pkg.sv
// Shared types and codes for the WebSocket frame deframer.
// No dependencies; imported by the parser, output stage and top level.
package wsfd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_CLOSE  = 3'd2,
    ST_UNMASK = 3'd3,
    ST_SHORT  = 3'd4
  } status_t;

  localparam logic [3:0] OPC_CLOSE   = 4'h8;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [2:0] KEY_BYTES    = 3'd4;

  // One result word handed from the parser to the output stage
  typedef struct packed {
    logic       have;
    logic [7:0] payload_byte;
    logic       payload_last;
    status_t    status;
  } result_t;

endpackage

// File: hw/rtl/wsfd_parser.sv
// Frame header parser and payload unmasker: holds the per-frame state and
// produces at most one result per accepted byte. Depends on wsfd_pkg.
module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_IDLE
  } phase_t;

  phase_t          phase, phase_next;
  // Frame length, counted down while payload bytes go out
  logic [63:0]     remaining, remaining_next;
  logic [3:0]      len_left, len_left_next;
  logic [3:0][7:0] mask_key, mask_key_next;
  logic [2:0]      key_left, key_left_next;
  logic [1:0]      key_idx, key_idx_next;
  logic            mask_present, mask_present_next;
  logic            close_seen, close_seen_next;

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    len_left_next     = len_left;
    mask_key_next     = mask_key;
    key_left_next     = key_left;
    key_idx_next      = key_idx;
    mask_present_next = mask_present;
    close_seen_next   = close_seen;
    res               = '0;
    res.status        = ST_DATA;

    case (phase)
      PH_HDR0: begin
        close_seen_next = (data_byte[3:0] == OPC_CLOSE);
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        if (close_seen) begin
          res.have   = 1'b1;
          res.status = ST_CLOSE;
          phase_next = PH_IDLE;
        end else begin
          mask_present_next = data_byte[7];
          remaining_next    = '0;
          if (data_byte[6:0] == LEN_CODE_16) begin
            len_left_next = EXT_BYTES_16;
            phase_next    = PH_EXTLEN;
          end else if (data_byte[6:0] == LEN_CODE_64) begin
            len_left_next = EXT_BYTES_64;
            phase_next    = PH_EXTLEN;
          end else begin
            remaining_next = {57'd0, data_byte[6:0]};
            if (!data_byte[7]) begin
              res.have   = 1'b1;
              res.status = ST_UNMASK;
              phase_next = PH_IDLE;
            end else begin
              key_left_next = KEY_BYTES;
              phase_next    = PH_MASK;
            end
          end
        end
      end
      PH_EXTLEN: begin
        remaining_next = {remaining[55:0], data_byte};
        len_left_next  = len_left - 4'd1;
        if (len_left == 4'd1) begin
          if (!mask_present) begin
            res.have   = 1'b1;
            res.status = ST_UNMASK;
            phase_next = PH_IDLE;
          end else begin
            key_left_next = KEY_BYTES;
            phase_next    = PH_MASK;
          end
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[2:0], data_byte};
        key_left_next = key_left - 3'd1;
        if (key_left == 3'd1) begin
          key_idx_next = '0;
          if (remaining == '0) begin
            res.have   = 1'b1;
            res.status = ST_EMPTY;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        // First key byte received sits in the top lane
        res.have         = 1'b1;
        res.payload_byte = data_byte ^ mask_key[~key_idx];
        key_idx_next     = key_idx + 2'd1;
        remaining_next   = remaining - 64'd1;
        if (remaining == 64'd1) begin
          res.payload_last = 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    // End of buffer: flag an unfinished frame, then start over
    if (end_of_buffer) begin
      if (phase_next != PH_IDLE) begin
        res.have         = 1'b1;
        res.status       = ST_SHORT;
        res.payload_byte = '0;
        res.payload_last = 1'b0;
      end
      phase_next        = PH_HDR0;
      remaining_next    = '0;
      len_left_next     = '0;
      mask_key_next     = '0;
      key_left_next     = '0;
      key_idx_next      = '0;
      mask_present_next = 1'b0;
      close_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      remaining    <= '0;
      len_left     <= '0;
      mask_key     <= '0;
      key_left     <= '0;
      key_idx      <= '0;
      mask_present <= 1'b0;
      close_seen   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      len_left     <= len_left_next;
      mask_key     <= mask_key_next;
      key_left     <= key_left_next;
      key_idx      <= key_idx_next;
      mask_present <= mask_present_next;
      close_seen   <= close_seen_next;
    end
  end

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (res.have && res.status != ST_DATA) |-> (res.payload_byte == '0 && !res.payload_last))
    else $error("non-data result carries payload bits");

  a_eob_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_buffer) |=> (phase == PH_HDR0))
    else $error("parser did not restart after end of buffer");

  a_mask_only_masked: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_MASK || phase == PH_PAYLOAD) |-> mask_present)
    else $error("unmasked frame reached key or payload");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining != '0))
    else $error("payload phase with no bytes left");

endmodule

// File: hw/rtl/wsfd_out_stage.sv
// Output register for deframer results with valid/ready handshake.
// Depends on wsfd_pkg for the result word.
module wsfd_out_stage
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       payload_last,
  output logic [2:0] status
);

  // Take a new word when empty or when the held word leaves this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && res.have) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.have) begin
      payload_byte <= res.payload_byte;
      payload_last <= res.payload_last;
      status       <= res.status;
    end
  end

endmodule

// File: hw/rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: parser plus output register.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_stage.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, data_byte, end_of_buffer | into block
//   out     | out_valid, out_ready, payload_byte,          | out of block
//           | payload_last, status                         |
//
// One byte per cycle: the header parse or unmask of a byte is one pass from
// the frame state to the output register, and a result appears the cycle after
// its byte is accepted. Bytes that give no result leave the output untouched.
// in_ready drops only while a result waits in the output register and
// out_ready is low. Synchronous reset clears the frame state and out_valid.
module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       payload_last,
  output logic [2:0] status
);

  result_t res;
  logic    can_load;
  logic    accept;

  assign in_ready = can_load;
  assign accept   = in_valid && can_load;

  wsfd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .res           (res)
  );

  wsfd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .res          (res),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .payload_last (payload_last),
    .status       (status)
  );

endmodule
